[rtl/tsa_pkg.sv]
// shared types and constants for the texture slot allocator
package tsa_pkg;

  // table geometry
  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int ID_W      = 32;
  localparam int IDX_W     = 32;
  localparam int CFG_W     = 11;

  // request codes
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_PLACE   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_ENABLED    = 1'b0;
  localparam logic [0:0] REG_SLOT_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    STAT_NEW       = 4'd0,
    STAT_EXISTING  = 4'd1,
    STAT_PLACED    = 4'd2,
    STAT_RELEASED  = 4'd3,
    STAT_DISABLED  = 4'd4,
    STAT_BAD_ID    = 4'd5,
    STAT_FULL      = 4'd6,
    STAT_BAD_INDEX = 4'd7,
    STAT_IGNORED   = 4'd8
  } status_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ID_W-1:0]  texture_id;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              write_descriptor;
    logic [CNT_W-1:0]  live_count;
  } rsp_t;

endpackage

[rtl/texture_slot_allocator.sv]
// texture slot allocator: owner table scan, free fifo and slot counter
// Operation: the owner table is scanned one entry a cycle, up to next_slot; a release and a
// failed check skip the scan. The result word is registered in S_DONE, which waits for the receiver.
// One word at a time: in_ready rises when the result word is registered.
// Reset (and every write of the enabled register) runs a clearing pass over the owner table,
// during which no word is accepted.
module texture_slot_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tsa_pkg::req_t                     in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tsa_pkg::rsp_t                     out_word,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [tsa_pkg::CFG_W-1:0]         cfg_data
);

  // local aliases of the request codes
  localparam logic [1:0] REQ_ALLOC_C   = tsa_pkg::REQ_ALLOC;
  localparam logic [1:0] REQ_PLACE_C   = tsa_pkg::REQ_PLACE;
  localparam logic [1:0] REQ_RELEASE_C = tsa_pkg::REQ_RELEASE;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_UNBIND, S_POP, S_COMMIT, S_RELEASE, S_DONE
  } state_t;

  state_t state;

  // configuration and counters
  logic                         enabled;
  logic [tsa_pkg::CFG_W-1:0]    slot_limit;
  logic [tsa_pkg::CNT_W-1:0]    next_slot;
  logic [tsa_pkg::CNT_W-1:0]    used_count;
  logic [tsa_pkg::SLOT_W-1:0]   free_head;
  logic [tsa_pkg::CNT_W-1:0]    free_fill;
  logic [tsa_pkg::SLOT_W-1:0]   clr_addr;

  // scan state
  logic [tsa_pkg::CNT_W-1:0]    scan_addr;
  logic                         pend;
  logic [tsa_pkg::SLOT_W-1:0]   pend_addr;
  logic [tsa_pkg::SLOT_W-1:0]   found_slot;

  // current word
  logic [1:0]                   cur_req;
  logic [tsa_pkg::ID_W-1:0]     cur_id;
  logic [tsa_pkg::SLOT_W-1:0]   cur_slot;
  tsa_pkg::status_t             res_status;
  logic [tsa_pkg::SLOT_W-1:0]   res_slot;
  logic                         res_wr;

  // owner table: {bound, owner id}
  logic [tsa_pkg::ID_W:0]       tab_mem [tsa_pkg::MAX_SLOTS];
  logic [tsa_pkg::ID_W:0]       tab_rd;
  logic                         tab_we;
  logic [tsa_pkg::SLOT_W-1:0]   tab_wa;
  logic [tsa_pkg::ID_W:0]       tab_wd;

  // free fifo
  logic [tsa_pkg::SLOT_W-1:0]   fifo_mem [tsa_pkg::MAX_SLOTS];
  logic [tsa_pkg::SLOT_W-1:0]   fifo_rd;
  logic                         fifo_we;
  logic [tsa_pkg::SLOT_W-1:0]   fifo_wa;

  logic [tsa_pkg::CNT_W-1:0]    eff_limit;
  logic                         issue;
  logic                         match;
  logic                         in_acc;
  logic                         idx_all_ones;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // effective limit, clamped to table depth
  assign eff_limit = (slot_limit < tsa_pkg::CFG_W'(tsa_pkg::MAX_SLOTS))
                     ? tsa_pkg::CNT_W'(slot_limit)
                     : tsa_pkg::CNT_W'(tsa_pkg::MAX_SLOTS);

  assign idx_all_ones = (in_word.slot_index == {tsa_pkg::IDX_W{1'b1}});

  // scan compare on the registered table read
  assign issue = (scan_addr < next_slot);
  assign match = pend && tab_rd[tsa_pkg::ID_W] && (tab_rd[tsa_pkg::ID_W-1:0] == cur_id);

  // table write port select
  always_comb begin
    tab_we = 1'b0;
    tab_wa = cur_slot;
    tab_wd = {1'b0, cur_id};
    unique case (state)
      S_CLEAR: begin
        tab_we = 1'b1;
        tab_wa = clr_addr;
        tab_wd = '0;
      end
      S_RELEASE: begin
        tab_we = 1'b1;
      end
      S_UNBIND: begin
        tab_we = 1'b1;
        tab_wa = found_slot;
      end
      S_COMMIT: begin
        tab_we = 1'b1;
        tab_wd = {1'b1, cur_id};
      end
      default: begin
        tab_we = 1'b0;
      end
    endcase
  end

  // fifo push on release unless full
  assign fifo_we = (state == S_RELEASE) && (free_fill < tsa_pkg::CNT_W'(tsa_pkg::MAX_SLOTS));
  assign fifo_wa = free_head + free_fill[tsa_pkg::SLOT_W-1:0];

  // owner table memory
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
    tab_rd <= tab_mem[scan_addr[tsa_pkg::SLOT_W-1:0]];
  end

  // free fifo memory
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_wa] <= cur_slot;
    end
    fifo_rd <= fifo_mem[free_head];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      enabled    <= 1'b0;
      slot_limit <= tsa_pkg::CFG_W'(tsa_pkg::MAX_SLOTS);
      next_slot  <= '0;
      used_count <= '0;
      free_head  <= '0;
      free_fill  <= '0;
      clr_addr   <= '0;
      scan_addr  <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      // enable write clears the counters and restarts the clearing pass
      if (cfg_we && cfg_index == tsa_pkg::REG_ENABLED) begin
        enabled    <= cfg_data[0];
        next_slot  <= '0;
        used_count <= '0;
        free_head  <= '0;
        free_fill  <= '0;
        clr_addr   <= '0;
        pend       <= 1'b0;
        state      <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == tsa_pkg::SLOT_W'(tsa_pkg::MAX_SLOTS - 1)) begin
              state <= S_IDLE;
            end
          end

          // check the word and pick the path
          S_IDLE: begin
            if (in_acc) begin
              cur_req    <= in_word.req_type;
              cur_id     <= in_word.texture_id;
              cur_slot   <= in_word.slot_index[tsa_pkg::SLOT_W-1:0];
              res_slot   <= '0;
              res_wr     <= 1'b0;
              scan_addr  <= '0;
              pend       <= 1'b0;
              state      <= S_DONE;
              if (in_word.req_type != REQ_ALLOC_C && in_word.req_type != REQ_PLACE_C &&
                  in_word.req_type != REQ_RELEASE_C) begin
                res_status <= tsa_pkg::STAT_IGNORED;
              end else if (!enabled) begin
                res_status <= tsa_pkg::STAT_DISABLED;
              end else if (in_word.req_type == REQ_ALLOC_C) begin
                if (in_word.texture_id == '0) begin
                  res_status <= tsa_pkg::STAT_BAD_ID;
                end else begin
                  state <= S_SCAN;
                end
              end else if (in_word.req_type == REQ_PLACE_C) begin
                if (idx_all_ones ||
                    in_word.slot_index >= tsa_pkg::IDX_W'(eff_limit)) begin
                  res_status <= tsa_pkg::STAT_BAD_INDEX;
                end else if (in_word.texture_id == '0) begin
                  res_status <= tsa_pkg::STAT_BAD_ID;
                end else begin
                  state <= S_SCAN;
                end
              end else begin
                if (idx_all_ones ||
                    in_word.slot_index >= tsa_pkg::IDX_W'(next_slot)) begin
                  res_status <= tsa_pkg::STAT_BAD_INDEX;
                end else begin
                  state <= S_RELEASE;
                end
              end
            end
          end

          // one table entry per cycle, compared in the cycle after its read is issued
          S_SCAN: begin
            if (match) begin
              pend <= 1'b0;
              if (cur_req == REQ_ALLOC_C) begin
                res_status <= tsa_pkg::STAT_EXISTING;
                res_slot   <= pend_addr;
                state      <= S_DONE;
              end else begin
                found_slot <= pend_addr;
                state      <= S_UNBIND;
              end
            end else if (!issue && !pend) begin
              if (cur_req == REQ_ALLOC_C) begin
                if (free_fill != '0) begin
                  free_head <= free_head + 1'b1;
                  free_fill <= free_fill - 1'b1;
                  state     <= S_POP;
                end else if (next_slot >= eff_limit) begin
                  res_status <= tsa_pkg::STAT_FULL;
                  state      <= S_DONE;
                end else begin
                  cur_slot  <= next_slot[tsa_pkg::SLOT_W-1:0];
                  next_slot <= next_slot + 1'b1;
                  state     <= S_COMMIT;
                end
              end else begin
                state <= S_COMMIT;
              end
            end else begin
              pend      <= issue;
              pend_addr <= scan_addr[tsa_pkg::SLOT_W-1:0];
              if (issue) begin
                scan_addr <= scan_addr + 1'b1;
              end
            end
          end

          // old slot of a placed id dropped by the table write
          S_UNBIND: begin
            state <= S_COMMIT;
          end

          // slot popped from the free fifo
          S_POP: begin
            cur_slot <= fifo_rd;
            state    <= S_COMMIT;
          end

          // bind id to slot
          S_COMMIT: begin
            res_slot <= cur_slot;
            res_wr   <= 1'b1;
            state    <= S_DONE;
            if (cur_req == REQ_PLACE_C) begin
              res_status <= tsa_pkg::STAT_PLACED;
              if ({1'b0, cur_slot} >= next_slot) begin
                next_slot <= {1'b0, cur_slot} + 1'b1;
              end
            end else begin
              res_status <= tsa_pkg::STAT_NEW;
              if (used_count < tsa_pkg::CNT_W'(tsa_pkg::MAX_SLOTS)) begin
                used_count <= used_count + 1'b1;
              end
            end
          end

          // unbind and push to the free fifo
          S_RELEASE: begin
            res_status <= tsa_pkg::STAT_RELEASED;
            res_slot   <= cur_slot;
            state      <= S_DONE;
            if (fifo_we) begin
              free_fill <= free_fill + 1'b1;
            end
            if (used_count != '0) begin
              used_count <= used_count - 1'b1;
            end
          end

          // hand the result to the output register
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid                 <= 1'b1;
              out_word.status           <= res_status;
              out_word.slot             <= res_slot;
              out_word.write_descriptor <= res_wr;
              out_word.live_count       <= used_count;
              state                     <= S_IDLE;
            end
          end

          default: begin
            state <= S_IDLE;
          end
        endcase
      end

      // slot limit write
      if (cfg_we && cfg_index == tsa_pkg::REG_SLOT_LIMIT) begin
        slot_limit <= cfg_data;
      end
    end
  end

endmodule

[rtl/tsa_checker.sv]
// port-level checks for the texture slot allocator, bound to the top level
module tsa_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input tsa_pkg::req_t             in_word,
  input logic                      out_valid,
  input logic                      out_ready,
  input tsa_pkg::rsp_t             out_word,
  input logic                      cfg_we,
  input logic [0:0]                cfg_index,
  input logic [tsa_pkg::CFG_W-1:0] cfg_data
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // clearing pass blocks input after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during clearing pass");

  // one word in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // descriptor write only on new or placed
  a_wr_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.write_descriptor |->
      out_word.status == tsa_pkg::STAT_NEW || out_word.status == tsa_pkg::STAT_PLACED)
    else $error("descriptor write on a failed or lookup result");

  // failed requests report slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status == tsa_pkg::STAT_DISABLED ||
                  out_word.status == tsa_pkg::STAT_BAD_ID ||
                  out_word.status == tsa_pkg::STAT_FULL ||
                  out_word.status == tsa_pkg::STAT_BAD_INDEX ||
                  out_word.status == tsa_pkg::STAT_IGNORED) |-> out_word.slot == '0)
    else $error("failed request reports a slot");

endmodule

bind texture_slot_allocator tsa_checker u_tsa_checker (.*);

[verif/texture_slot_allocator_tb.sv]
// testbench for texture_slot_allocator: directed and random requests checked against a slot table model
module texture_slot_allocator_tb;
  import tsa_pkg::*;

  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
  localparam logic [31:0] NO_SLOT     = 32'hFFFF_FFFF;
  localparam int          ID_POOL     = 12;
  localparam int          HOLD_CYCLES = 600;
  localparam int          RING_BURST  = 8;
  // covers a clearing pass, a full-depth scan and the long receiver hold, several times over
  localparam int          WATCHDOG    = 20000;

  // expected grants of the allocator, kept in request order
  class alloc_scoreboard;
    logic [ID_W-1:0]   owner [MAX_SLOTS];
    bit                bound [MAX_SLOTS];
    logic [SLOT_W-1:0] free_ring [MAX_SLOTS];
    int unsigned       ring_head;
    int unsigned       ring_fill;
    int unsigned       next_slot;
    int unsigned       live;
    bit                enabled;
    int unsigned       limit;
    rsp_t              grant_q [$];
    int                errors;

    function new();
      clear_tables();
      enabled = 1'b0;
      limit = MAX_SLOTS;
      errors = 0;
    endfunction

    function void clear_tables();
      foreach (bound[i]) bound[i] = 1'b0;
      ring_head = 0;
      ring_fill = 0;
      next_slot = 0;
      live = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_ENABLED) begin
        clear_tables();
        enabled = data[0];
      end else begin
        limit = data;
      end
    endfunction

    function int unsigned eff_limit();
      return (limit < MAX_SLOTS) ? limit : MAX_SLOTS;
    endfunction

    // bound slot below next_slot that holds this id, or -1
    function int find_owner(logic [ID_W-1:0] id);
      int hit;
      hit = -1;
      for (int s = 0; s < next_slot && s < MAX_SLOTS; s++) begin
        if (hit < 0 && bound[s] && owner[s] == id) hit = s;
      end
      return hit;
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    // work out the grant for an accepted request word and queue it
    function void note_request(req_t w);
      rsp_t r;
      int   hit;
      int   s;
      r.status = STAT_IGNORED;
      r.slot = '0;
      r.write_descriptor = 1'b0;
      if (w.req_type == REQ_UNKNOWN) begin
        r.status = STAT_IGNORED;
      end else if (!enabled) begin
        r.status = STAT_DISABLED;
      end else if (w.req_type == REQ_ALLOC) begin
        if (w.texture_id == '0) begin
          r.status = STAT_BAD_ID;
        end else begin
          hit = find_owner(w.texture_id);
          if (hit >= 0) begin
            r.status = STAT_EXISTING;
            r.slot = SLOT_W'(hit);
          end else begin
            s = -1;
            // recycled slots first, then the counter
            if (ring_fill > 0) begin
              s = free_ring[ring_head];
              ring_head = (ring_head + 1) % MAX_SLOTS;
              ring_fill--;
            end else if (next_slot < eff_limit()) begin
              s = next_slot;
              next_slot++;
            end
            if (s < 0) begin
              r.status = STAT_FULL;
            end else begin
              owner[s] = w.texture_id;
              bound[s] = 1'b1;
              if (live < MAX_SLOTS) live++;
              r.status = STAT_NEW;
              r.slot = SLOT_W'(s);
              r.write_descriptor = 1'b1;
            end
          end
        end
      end else if (w.req_type == REQ_PLACE) begin
        // index is checked before the id
        if (w.slot_index == NO_SLOT || w.slot_index >= eff_limit()) begin
          r.status = STAT_BAD_INDEX;
        end else if (w.texture_id == '0) begin
          r.status = STAT_BAD_ID;
        end else begin
          s = int'(w.slot_index);
          hit = find_owner(w.texture_id);
          if (hit >= 0) bound[hit] = 1'b0;
          owner[s] = w.texture_id;
          bound[s] = 1'b1;
          if (s >= next_slot) next_slot = s + 1;
          r.status = STAT_PLACED;
          r.slot = SLOT_W'(s);
          r.write_descriptor = 1'b1;
        end
      end else begin
        // release: unbound slots are still pushed, a full ring drops the push
        if (w.slot_index == NO_SLOT || w.slot_index >= next_slot) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          s = int'(w.slot_index);
          bound[s] = 1'b0;
          if (ring_fill < MAX_SLOTS) begin
            free_ring[(ring_head + ring_fill) % MAX_SLOTS] = SLOT_W'(s);
            ring_fill++;
          end
          if (live > 0) live--;
          r.status = STAT_RELEASED;
          r.slot = SLOT_W'(s);
        end
      end
      r.live_count = CNT_W'(live);
      grant_q.push_back(r);
    endfunction

    // compare a result word with the oldest expected grant
    function void check_grant(rsp_t got);
      rsp_t want;
      if (grant_q.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d", got.status, got.slot);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got.slot);
          errors++;
        end
        if (got.write_descriptor !== want.write_descriptor) begin
          $error("write_descriptor: expected %0d, got %0d",
                 want.write_descriptor, got.write_descriptor);
          errors++;
        end
        if (got.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  req_t               in_word;
  logic               out_valid;
  logic               out_ready;
  rsp_t               out_word;
  logic               cfg_we;
  logic [0:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  alloc_scoreboard    sb;
  logic [ID_W-1:0]    id_pool [ID_POOL];
  bit                 offering = 1'b0;
  bit                 send_calm = 1'b0;
  bit                 hold_off_req = 1'b0;
  int                 quiet_cycles = 0;

  texture_slot_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic req_t pack_req(logic [1:0] kind, logic [ID_W-1:0] id,
                                    logic [IDX_W-1:0] idx);
    req_t w;
    w.req_type = kind;
    w.texture_id = id;
    w.slot_index = idx;
    return w;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 75) return id_pool[$urandom_range(ID_POOL - 1)];
    return $urandom();
  endfunction

  // mostly in range, the rest invalid, just past the bound or anywhere
  function automatic logic [IDX_W-1:0] pick_index(int unsigned bound, int unsigned wide);
    int r;
    r = $urandom_range(99);
    if (r < 80 && bound > 0) return IDX_W'($urandom_range(bound - 1));
    if (r < 86 && wide > 0) return IDX_W'($urandom_range(wide - 1));
    if (r < 92) return NO_SLOT;
    if (r < 96) return IDX_W'(wide + $urandom_range(3));
    return $urandom();
  endfunction

  // place indexes stay below reach most of the time to keep scans short
  function automatic req_t make_request(int unsigned reach);
    req_t        w;
    int          r;
    int unsigned lim;
    lim = sb.eff_limit();
    r = $urandom_range(99);
    w.texture_id = pick_id();
    w.slot_index = $urandom();
    if (r < 45) begin
      w.req_type = REQ_ALLOC;
    end else if (r < 70) begin
      w.req_type = REQ_PLACE;
      w.slot_index = pick_index((reach < lim) ? reach : lim, lim);
    end else if (r < 95) begin
      w.req_type = REQ_RELEASE;
      w.slot_index = pick_index(sb.next_slot, sb.next_slot);
    end else begin
      w.req_type = REQ_UNKNOWN;
    end
    return w;
  endfunction

  task automatic drop_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // offer one request word and hold it until accepted
  task automatic send_word(req_t w);
    int gap;
    if ($urandom_range(49) == 0) send_calm = !send_calm;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(w);
  endtask

  task automatic wait_idle();
    drop_valid();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(int unsigned lim, bit fresh, bit en, int count,
                           int unsigned reach, bit hold);
    write_reg(REG_SLOT_LIMIT, CFG_W'(lim));
    if (fresh) write_reg(REG_ENABLED, {10'($urandom()), en});
    if (hold) hold_off_req = 1'b1;
    repeat (count) send_word(make_request(reach));
    wait_idle();
  endtask

  // release one slot over and over until live count saturates, then drain the ring
  // and fall back to the counter
  task automatic run_ring_fill();
    write_reg(REG_SLOT_LIMIT, CFG_W'(MAX_SLOTS));
    write_reg(REG_ENABLED, CFG_W'(1));
    send_word(pack_req(REQ_ALLOC, 32'h0BAD_F00D, $urandom()));
    for (int k = 0; k < RING_BURST; k++) begin
      send_word(pack_req(REQ_RELEASE, $urandom(), '0));
    end
    for (int k = 0; k < RING_BURST + 2; k++) begin
      send_word(pack_req(REQ_ALLOC, 32'h4000_0000 + ID_W'(k), $urandom()));
    end
    wait_idle();
  endtask

  // receiver: random stalls plus one long hold on request
  initial begin : sink
    int stall_left;
    bit calm;
    stall_left = 0;
    calm = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(299) == 0) calm = !calm;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(3) == 0) stall_left = pick_gap(calm);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_grant(out_word);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ENABLED;
    cfg_data <= '0;
    id_pool[0] = 32'hFFFF_FFFF;
    id_pool[1] = 32'd1;
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = $urandom() | 32'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // disabled after reset, unknown type ignored
    send_word(pack_req(REQ_ALLOC, 32'd5, 32'd0));
    send_word(pack_req(REQ_PLACE, 32'd5, 32'd0));
    send_word(pack_req(REQ_RELEASE, 32'd5, 32'd0));
    send_word(pack_req(REQ_UNKNOWN, 32'hFFFF_FFFF, NO_SLOT));

    // limit below one
    write_reg(REG_SLOT_LIMIT, CFG_W'(0));
    write_reg(REG_ENABLED, CFG_W'(1));
    send_word(pack_req(REQ_ALLOC, 32'd7, 32'd0));
    send_word(pack_req(REQ_PLACE, 32'd7, 32'd0));
    send_word(pack_req(REQ_RELEASE, 32'd7, 32'd0));

    // small table: lookup, id checks, place and release corners
    write_reg(REG_SLOT_LIMIT, CFG_W'(4));
    send_word(pack_req(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0));
    send_word(pack_req(REQ_ALLOC, 32'hFFFF_FFFF, NO_SLOT));
    send_word(pack_req(REQ_ALLOC, 32'd0, 32'd1));
    send_word(pack_req(REQ_PLACE, 32'd0, NO_SLOT));
    send_word(pack_req(REQ_PLACE, 32'd0, 32'd2));
    send_word(pack_req(REQ_PLACE, 32'd9, 32'd4));
    send_word(pack_req(REQ_PLACE, 32'hFFFF_FFFF, 32'd3));
    send_word(pack_req(REQ_RELEASE, 32'd1, NO_SLOT));
    send_word(pack_req(REQ_RELEASE, 32'd1, 32'd4));
    send_word(pack_req(REQ_RELEASE, 32'd1, 32'd0));
    send_word(pack_req(REQ_RELEASE, 32'd1, 32'd1));
    send_word(pack_req(REQ_PLACE, 32'd11, 32'd1));
    send_word(pack_req(REQ_ALLOC, 32'd12, 32'd0));
    send_word(pack_req(REQ_ALLOC, 32'd13, 32'd0));
    send_word(pack_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'd0));
    send_word(pack_req(REQ_RELEASE, 32'd1, 32'd3));

    // popped slot above a lowered limit, then counter full
    write_reg(REG_SLOT_LIMIT, CFG_W'(2));
    send_word(pack_req(REQ_ALLOC, 32'd14, 32'd0));
    send_word(pack_req(REQ_ALLOC, 32'd15, 32'd0));

    run_ring_fill();

    // random phases over several limits, one with a long receiver hold
    run_phase(6, 1'b1, 1'b1, 90, 6, 1'b0);
    run_phase(1, 1'b0, 1'b1, 40, 1, 1'b0);
    run_phase(16, 1'b1, 1'b1, 100, 16, 1'b1);
    run_phase(40, 1'b0, 1'b1, 100, 40, 1'b0);
    run_phase(2047, 1'b0, 1'b1, 60, 24, 1'b0);
    run_phase(1024, 1'b1, 1'b0, 20, 8, 1'b0);
    run_phase(3, 1'b1, 1'b1, 80, 3, 1'b0);
    run_phase(1024, 1'b1, 1'b1, 40, 1024, 1'b0);
    run_phase(0, 1'b0, 1'b1, 20, 0, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/tsa_pkg.sv
rtl/texture_slot_allocator.sv
rtl/tsa_checker.sv
verif/texture_slot_allocator_tb.sv
